// ===== sv/wtm_pkg.sv =====
package wtm_pkg;

  localparam int RamDepth = 128;
  localparam int RamAw = $clog2(RamDepth);
  localparam int IrqLimit = 32768;
  localparam int CntW = 15;

  typedef enum logic [2:0] {
    CMD_READ      = 3'd0,
    CMD_WRITE     = 3'd1,
    CMD_TICK      = 3'd2,
    CMD_PPU_XLATE = 3'd3,
    CMD_PRG_XLATE = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    TGT_NONE    = 3'd0,
    TGT_PRG_ROM = 3'd1,
    TGT_CHR_ROM = 3'd2,
    TGT_CHR_RAM = 3'd3,
    TGT_CIRAM   = 3'd4
  } target_e;

  // decoded operation kinds
  typedef enum logic [3:0] {
    OP_NOP, OP_RD_PORT, OP_RD_CNT_LO, OP_RD_CNT_HI, OP_WR_PORT, OP_WR_CNT_LO,
    OP_WR_CNT_HI, OP_WR_CHR, OP_WR_NT, OP_WR_PRG0, OP_WR_PRG1, OP_WR_PRG2,
    OP_WR_PORTADDR, OP_TICK, OP_XL_CHR, OP_XL_NT
  } op_e;

  typedef struct packed {
    op_e        op;
    logic       prg_xl;
    logic [2:0] slot;
    logic [7:0] data;
  } uop_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       read_valid;
    logic       irq_line;
    logic [2:0] target;
    logic [7:0] bank;
  } res_t;

endpackage

// ===== sv/wtm_front.sv =====
module wtm_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  logic [2:0]    cmd_i,
  input  logic [15:0]   address_i,
  input  logic [7:0]    write_data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output wtm_pkg::uop_t uop_o
);
  import wtm_pkg::*;

  uop_t uop_d, uop_q;
  logic valid_q;
  logic [4:0] a_hi;

  assign a_hi = address_i[15:11];

  // classify the item by command and address range
  always_comb begin
    uop_d = '0;
    uop_d.op = OP_NOP;
    uop_d.data = write_data_i;
    uop_d.slot = address_i[13:11];
    unique case (cmd_i)
      CMD_READ: begin
        if (a_hi == 5'h09) uop_d.op = OP_RD_PORT;
        else if (a_hi == 5'h0A) uop_d.op = OP_RD_CNT_LO;
        else if (a_hi == 5'h0B) uop_d.op = OP_RD_CNT_HI;
      end
      CMD_WRITE: begin
        if (a_hi == 5'h09) uop_d.op = OP_WR_PORT;
        else if (a_hi == 5'h0A) uop_d.op = OP_WR_CNT_LO;
        else if (a_hi == 5'h0B) uop_d.op = OP_WR_CNT_HI;
        else if (address_i[15:14] == 2'b10) uop_d.op = OP_WR_CHR;
        else if (address_i[15:13] == 3'b110) uop_d.op = OP_WR_NT;
        else if (a_hi == 5'h1C) uop_d.op = OP_WR_PRG0;
        else if (a_hi == 5'h1D) uop_d.op = OP_WR_PRG1;
        else if (a_hi == 5'h1E) uop_d.op = OP_WR_PRG2;
        else if (a_hi == 5'h1F) uop_d.op = OP_WR_PORTADDR;
      end
      CMD_TICK: uop_d.op = OP_TICK;
      CMD_PPU_XLATE: begin
        uop_d.slot = address_i[12:10];
        if (address_i[15:13] == 3'b000) uop_d.op = OP_XL_CHR;
        else if (address_i[15:12] == 4'h2) uop_d.op = OP_XL_NT;
      end
      CMD_PRG_XLATE: begin
        uop_d.prg_xl = address_i[15];
        uop_d.slot = {1'b0, address_i[14:13]};
      end
      default: uop_d.op = OP_NOP;
    endcase
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign uop_o = uop_q;

  // single stage decode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) uop_q <= uop_d;
  end

endmodule

// ===== sv/wtm_queue.sv =====
module wtm_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  wtm_pkg::uop_t uop_i,
  output logic          valid_o,
  input  logic          ready_i,
  output wtm_pkg::uop_t uop_o
);
  import wtm_pkg::*;

  uop_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic push, pop;

  assign ready_o = cnt_q != 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign uop_o = mem_q[rp_q];
  assign push = valid_i && ready_o;
  assign pop = valid_o && ready_i;

  // two entry fifo pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= !wp_q;
      if (pop) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= uop_i;
  end

endmodule

// ===== sv/wtm_back.sv =====
module wtm_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  wtm_pkg::uop_t uop_i,
  output logic          valid_o,
  input  logic          ready_i,
  output wtm_pkg::res_t res_o
);
  import wtm_pkg::*;

  localparam logic [CntW-1:0] CntMax = CntW'(IrqLimit - 1);

  logic [7:0] ram_q [RamDepth];
  logic [RamAw-1:0] port_addr_q;
  logic port_inc_q;
  logic [CntW-1:0] cnt_q;
  logic irq_en_q, irq_pend_q;
  logic [7:0] chr_q [8];
  logic [7:0] nt_q [4];
  logic [5:0] prg_q [3];
  logic [1:0] ctl_q;

  // result stage: ram data read and late fields combined at the output
  logic valid_q;
  res_t res_q;
  logic sel_ram_q;
  logic [7:0] ram_rd_q;
  logic go;
  logic is_irq_wr;
  logic [CntW:0] cnt_inc;
  res_t res_d;
  logic [7:0] b;
  logic ctl;

  assign ready_o = !valid_q || ready_i;
  assign go = valid_i && ready_o;
  assign valid_o = valid_q;
  assign is_irq_wr = uop_i.op == OP_WR_CNT_LO || uop_i.op == OP_WR_CNT_HI;
  assign cnt_inc = {1'b0, cnt_q} + 1'b1;

  always_comb begin
    res_o = res_q;
    if (sel_ram_q) res_o.read_data = ram_rd_q;
  end

  // result fields that depend on current state
  always_comb begin
    res_d = '0;
    b = 8'h00;
    ctl = 1'b0;
    case (uop_i.op)
      OP_RD_CNT_LO: begin
        res_d.read_valid = 1'b1;
        res_d.read_data = cnt_q[7:0];
      end
      OP_RD_CNT_HI: begin
        res_d.read_valid = 1'b1;
        res_d.read_data = {1'b0, cnt_q[14:8]};
      end
      OP_RD_PORT: res_d.read_valid = 1'b1;
      OP_XL_CHR: begin
        b = chr_q[uop_i.slot];
        ctl = uop_i.slot[2] ? ctl_q[1] : ctl_q[0];
        res_d.target = (b >= 8'hE0 && !ctl) ? TGT_CHR_RAM : TGT_CHR_ROM;
        res_d.bank = b;
      end
      OP_XL_NT: begin
        b = nt_q[uop_i.slot[1:0]];
        if (b >= 8'hE0) begin
          res_d.target = TGT_CIRAM;
          res_d.bank = {7'd0, b[0]};
        end else begin
          res_d.target = TGT_CHR_ROM;
          res_d.bank = b;
        end
      end
      default: ;
    endcase
    if (uop_i.prg_xl) begin
      res_d.target = TGT_PRG_ROM;
      res_d.bank = (uop_i.slot[1:0] == 2'd3) ? 8'h3F : {2'b00, prg_q[uop_i.slot[1:0]]};
    end
    // irq line after this item
    if (is_irq_wr) res_d.irq_line = 1'b0;
    else if (uop_i.op == OP_TICK && irq_en_q && cnt_inc >= (CntW+1)'(IrqLimit))
      res_d.irq_line = 1'b1;
    else res_d.irq_line = irq_pend_q;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      port_addr_q <= '0;
      port_inc_q <= 1'b1;
      cnt_q <= '0;
      irq_en_q <= 1'b0;
      irq_pend_q <= 1'b0;
      ctl_q <= 2'b00;
      for (int i = 0; i < 8; i++) chr_q[i] <= 8'h00;
      for (int i = 0; i < 4; i++) nt_q[i] <= 8'h00;
      for (int i = 0; i < 3; i++) prg_q[i] <= 6'h00;
    end else begin
      if (ready_o) valid_q <= valid_i;
      if (go) begin
        irq_pend_q <= res_d.irq_line;
        case (uop_i.op)
          OP_RD_PORT, OP_WR_PORT: port_addr_q <= port_addr_q + RamAw'(port_inc_q);
          OP_WR_CNT_LO: cnt_q[7:0] <= uop_i.data;
          OP_WR_CNT_HI: begin
            cnt_q[14:8] <= uop_i.data[6:0];
            irq_en_q <= uop_i.data[7];
          end
          OP_WR_CHR: chr_q[uop_i.slot] <= uop_i.data;
          OP_WR_NT: nt_q[uop_i.slot[1:0]] <= uop_i.data;
          OP_WR_PRG0: prg_q[0] <= uop_i.data[5:0];
          OP_WR_PRG1: begin
            prg_q[1] <= uop_i.data[5:0];
            ctl_q <= uop_i.data[7:6];
          end
          OP_WR_PRG2: prg_q[2] <= uop_i.data[5:0];
          OP_WR_PORTADDR: begin
            port_addr_q <= uop_i.data[RamAw-1:0];
            port_inc_q <= uop_i.data[7];
          end
          OP_TICK: begin
            if (irq_en_q) begin
              if (cnt_inc >= (CntW+1)'(IrqLimit)) begin
                cnt_q <= CntMax;
                irq_en_q <= 1'b0;
              end else begin
                cnt_q <= cnt_inc[CntW-1:0];
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  // expansion ram, zeroed by a clearing pass after reset, one port per cycle
  logic [RamAw:0] clr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_q <= '0;
    else if (!clr_q[RamAw]) clr_q <= clr_q + 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (!clr_q[RamAw]) begin
      ram_q[clr_q[RamAw-1:0]] <= 8'h00;
    end else if (go && uop_i.op == OP_WR_PORT) begin
      ram_q[port_addr_q] <= uop_i.data;
    end
    if (go) begin
      ram_rd_q <= ram_q[port_addr_q];
      sel_ram_q <= uop_i.op == OP_RD_PORT;
      res_q <= res_d;
    end
  end

endmodule

// ===== sv/wavetable_mapper_register_block.sv =====
// Mapper register block: expansion ram port, cycle irq counter and bank
// registers for pattern, nametable and program space.
// Input channel s_axis carries one item per transfer: cmd, address and
// write_data. Each item gives exactly one result on m_axis: read_data,
// read_valid, irq_line, target and bank, in order.
// The result passes a decode register, then a two entry queue, then the
// execute stage whose output register holds the result. Throughput is one
// item per cycle while the receiver takes results and the ram clear is done;
// state updates in the execute stage and the next item sees them.
// After reset the bank registers, counter and irq state are zero, auto
// increment is set, and the expansion ram is cleared by a pass over its 128
// entries, during which s_axis_tready stays low.
// When the receiver stalls, the output register holds, the queue fills and
// then s_axis_tready drops; no item is lost or repeated.
module wavetable_mapper_register_block (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // cmd[2:0], address[18:3], write_data[26:19]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata   // read_data, read_valid, irq_line, target, bank
);
  import wtm_pkg::*;

  uop_t f_uop, q_uop;
  res_t res;
  logic f_valid, f_ready, q_valid, q_ready, fe_ready;
  logic [RamAw:0] boot_q;
  logic booted;

  // input stall while the ram clear runs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) boot_q <= '0;
    else if (!boot_q[RamAw]) boot_q <= boot_q + 1'b1;
  end
  assign booted = boot_q[RamAw];
  assign s_axis_tready = fe_ready && booted;

  wtm_front u_front (
    .clk_i, .rst_ni,
    .valid_i(s_axis_tvalid && booted), .ready_o(fe_ready),
    .cmd_i(s_axis_tdata[2:0]), .address_i(s_axis_tdata[18:3]),
    .write_data_i(s_axis_tdata[26:19]),
    .valid_o(f_valid), .ready_i(f_ready), .uop_o(f_uop)
  );

  wtm_queue u_queue (
    .clk_i, .rst_ni,
    .valid_i(f_valid), .ready_o(f_ready), .uop_i(f_uop),
    .valid_o(q_valid), .ready_i(q_ready), .uop_o(q_uop)
  );

  wtm_back u_back (
    .clk_i, .rst_ni,
    .valid_i(q_valid), .ready_o(q_ready), .uop_i(q_uop),
    .valid_o(m_axis_tvalid), .ready_i(m_axis_tready), .res_o(res)
  );

  assign m_axis_tdata = {3'b000, res.bank, res.target, res.irq_line, res.read_valid,
                         res.read_data};

endmodule

// ===== sv/wtm_checker.sv =====
module wtm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [31:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);
  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");
  // read_valid only with zero target
  a_rv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[8] |-> m_axis_tdata[12:10] == 3'd0)
    else $error("read with translate target");
  // nametable ram bank is one bit
  a_nt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[12:10] == 3'd4 |-> m_axis_tdata[20:14] == 7'd0)
    else $error("console ram bank too wide");
  // no result without an earlier input
  a_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 3) || $past(m_axis_tvalid))
    else $error("result without input");
endmodule

bind wavetable_mapper_register_block wtm_checker u_checker (.*);

// ===== test/wavetable_mapper_register_block_tb.sv =====
module wavetable_mapper_register_block_tb;
  import wtm_pkg::*;

  // predicted mapper state and the results still owed by the block
  class mapper_scoreboard;
    logic [7:0]  xram [RamDepth];
    logic [6:0]  port_addr;
    logic        port_inc;
    logic [14:0] irq_cnt;
    logic        irq_en;
    logic        irq_pend;
    logic [7:0]  chr_bank [8];
    logic [7:0]  nt_bank [4];
    logic [5:0]  prg_bank [3];
    logic [1:0]  chr_ram_ctl;
    res_t        owed_results [$];
    int          mismatches;

    function new();
      foreach (xram[i]) xram[i] = '0;
      foreach (chr_bank[i]) chr_bank[i] = '0;
      foreach (nt_bank[i]) nt_bank[i] = '0;
      foreach (prg_bank[i]) prg_bank[i] = '0;
      port_addr = '0;
      port_inc = 1'b1;
      irq_cnt = '0;
      irq_en = 1'b0;
      irq_pend = 1'b0;
      chr_ram_ctl = '0;
      mismatches = 0;
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

    // apply one accepted transfer to the state and queue its result
    function void note_item(logic [2:0] c, logic [15:0] a, logic [7:0] d);
      res_t r;
      logic [7:0] b;
      logic ctl;
      r = '0;
      case (c)
        CMD_READ: begin
          if (a >= 16'h4800 && a < 16'h5000) begin
            r.read_data = xram[port_addr];
            port_addr = port_addr + 7'(port_inc);
            r.read_valid = 1'b1;
          end else if (a >= 16'h5000 && a < 16'h5800) begin
            r.read_data = irq_cnt[7:0];
            r.read_valid = 1'b1;
          end else if (a >= 16'h5800 && a < 16'h6000) begin
            r.read_data = {1'b0, irq_cnt[14:8]};
            r.read_valid = 1'b1;
          end
        end
        CMD_WRITE: begin
          if (a >= 16'h4800 && a < 16'h5000) begin
            xram[port_addr] = d;
            port_addr = port_addr + 7'(port_inc);
          end else if (a >= 16'h5000 && a < 16'h5800) begin
            irq_cnt[7:0] = d;
            irq_pend = 1'b0;
          end else if (a >= 16'h5800 && a < 16'h6000) begin
            irq_cnt[14:8] = d[6:0];
            irq_en = d[7];
            irq_pend = 1'b0;
          end else if (a >= 16'h8000 && a < 16'hC000) begin
            chr_bank[a[13:11]] = d;
          end else if (a >= 16'hC000 && a < 16'hE000) begin
            nt_bank[a[12:11]] = d;
          end else if (a >= 16'hE000 && a < 16'hE800) begin
            prg_bank[0] = d[5:0];
          end else if (a >= 16'hE800 && a < 16'hF000) begin
            prg_bank[1] = d[5:0];
            chr_ram_ctl = d[7:6];
          end else if (a >= 16'hF000 && a < 16'hF800) begin
            prg_bank[2] = d[5:0];
          end else if (a >= 16'hF800) begin
            port_addr = d[6:0];
            port_inc = d[7];
          end
        end
        CMD_TICK: begin
          // saturate at the limit, then drop enable and raise the line
          if (irq_en) begin
            if (32'(irq_cnt) + 1 >= IrqLimit) begin
              irq_cnt = 15'(IrqLimit - 1);
              irq_en = 1'b0;
              irq_pend = 1'b1;
            end else begin
              irq_cnt = irq_cnt + 15'd1;
            end
          end
        end
        CMD_PPU_XLATE: begin
          if (a < 16'h2000) begin
            b = chr_bank[a[12:10]];
            ctl = a[12] ? chr_ram_ctl[1] : chr_ram_ctl[0];
            r.target = (b >= 8'hE0 && !ctl) ? TGT_CHR_RAM : TGT_CHR_ROM;
            r.bank = b;
          end else if (a < 16'h3000) begin
            b = nt_bank[a[11:10]];
            if (b >= 8'hE0) begin
              r.target = TGT_CIRAM;
              r.bank = {7'd0, b[0]};
            end else begin
              r.target = TGT_CHR_ROM;
              r.bank = b;
            end
          end
        end
        CMD_PRG_XLATE: begin
          if (a >= 16'h8000) begin
            r.target = TGT_PRG_ROM;
            r.bank = (a[14:13] == 2'd3) ? 8'h3F : {2'b0, prg_bank[a[14:13]]};
          end
        end
        default: ;
      endcase
      r.irq_line = irq_pend;
      owed_results.push_back(r);
    endfunction

    // compare one output transfer with the oldest owed result
    function void check_result(logic [23:0] t);
      res_t w;
      res_t g;
      g.read_data = t[7:0];
      g.read_valid = t[8];
      g.irq_line = t[9];
      g.target = t[12:10];
      g.bank = t[20:13];
      if (owed_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", t);
        return;
      end
      w = owed_results.pop_front();
      if (w != g || t[23:21] != 3'd0) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: exp rd=%h rv=%b irq=%b tgt=%0d bank=%h, ",
                    "got rd=%h rv=%b irq=%b tgt=%0d bank=%h"},
                   w.read_data, w.read_valid, w.irq_line, w.target, w.bank,
                   g.read_data, g.read_valid, g.irq_line, g.target, g.bank);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;

  mapper_scoreboard sb;
  logic calm;
  logic hold_trig;
  logic hold_seen;
  int   hold_left;

  wavetable_mapper_register_block uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  // clock
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // receiver: check transfers, random stalls and long hold-offs
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    if (hold_trig != hold_seen) begin
      hold_seen <= hold_trig;
      hold_left <= 300;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= 22);
    end
  end

  // offer one item and wait for its transfer
  task automatic send_item(logic [2:0] c, logic [15:0] a, logic [7:0] d);
    int gap;
    gap = (!calm && $urandom_range(99) < 22) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'd0, d, a, c};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(c, a, d);
  endtask

  // random item with addresses biased toward decoded regions
  task automatic send_random();
    logic [2:0]  c;
    logic [15:0] a;
    int k;
    k = $urandom_range(99);
    if (k < 3) c = 3'($urandom_range(5, 7));
    else if (k < 20) c = CMD_READ;
    else if (k < 50) c = CMD_WRITE;
    else if (k < 62) c = CMD_TICK;
    else if (k < 85) c = CMD_PPU_XLATE;
    else c = CMD_PRG_XLATE;
    k = $urandom_range(9);
    if (c == CMD_PPU_XLATE) a = (k < 8) ? 16'($urandom_range(16'h2FFF)) : 16'($urandom);
    else if (k < 3) a = 16'($urandom_range(16'h4800, 16'h5FFF));
    else if (k < 8) a = 16'($urandom_range(16'h8000, 16'hFFFF));
    else a = 16'($urandom);
    send_item(c, a, 8'($urandom));
  endtask

  // bring the counter near the limit and tick it into saturation
  task automatic irq_burst();
    send_item(CMD_WRITE, 16'h5000, 8'($urandom_range(16'hE0, 16'hFF)));
    send_item(CMD_WRITE, 16'h5800, 8'hFF);
    repeat ($urandom_range(10, 40)) send_item(CMD_TICK, 16'($urandom), 8'($urandom));
    send_item(CMD_READ, 16'h5000, 8'h00);
    send_item(CMD_READ, 16'h5FFF, 8'h00);
  endtask

  initial begin
    sb = new();
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    calm = 1'b0;
    hold_trig = 1'b0;
    hold_seen = 1'b0;
    hold_left = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: region edges, every command, open cases
    send_item(CMD_READ, 16'h47FF, 8'h00);
    send_item(CMD_WRITE, 16'hF800, 8'h85);
    send_item(CMD_WRITE, 16'h4800, 8'hAA);
    send_item(CMD_WRITE, 16'h4FFF, 8'h55);
    send_item(CMD_WRITE, 16'hFFFF, 8'h05);
    send_item(CMD_READ, 16'h4800, 8'h00);
    send_item(CMD_READ, 16'h4FFF, 8'h00);
    send_item(CMD_WRITE, 16'h6000, 8'hFF);
    send_item(CMD_WRITE, 16'h8000, 8'hE0);
    send_item(CMD_WRITE, 16'hBFFF, 8'hFF);
    send_item(CMD_WRITE, 16'hC000, 8'hE1);
    send_item(CMD_WRITE, 16'hDFFF, 8'h10);
    send_item(CMD_WRITE, 16'hE000, 8'hFF);
    send_item(CMD_WRITE, 16'hE800, 8'hC5);
    send_item(CMD_WRITE, 16'hF000, 8'h2A);
    send_item(CMD_PPU_XLATE, 16'h0000, 8'h00);
    send_item(CMD_PPU_XLATE, 16'h1FFF, 8'h00);
    send_item(CMD_PPU_XLATE, 16'h2000, 8'h00);
    send_item(CMD_PPU_XLATE, 16'h2FFF, 8'h00);
    send_item(CMD_PPU_XLATE, 16'h3000, 8'h00);
    send_item(CMD_PRG_XLATE, 16'h7FFF, 8'h00);
    send_item(CMD_PRG_XLATE, 16'hA000, 8'h00);
    send_item(CMD_PRG_XLATE, 16'hFFFF, 8'h00);
    send_item(3'd7, 16'hFFFF, 8'hFF);
    irq_burst();
    send_item(CMD_WRITE, 16'h57FF, 8'h00);

    // random phase with pressure events
    for (int n = 0; n < 720; n++) begin
      if (n == 200) calm <= 1'b1;
      if (n == 350) calm <= 1'b0;
      if (n == 400) hold_trig <= ~hold_trig;
      if (n == 600) begin
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk_i);
      end
      if (n % 120 == 60) irq_burst();
      else send_random();
    end
    s_axis_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0) $display("wavetable_mapper_register_block test passed");
    else $display("wavetable_mapper_register_block test failed");
    $finish;
  end

  // run limit
  initial begin
    #4000000;
    $display("wavetable_mapper_register_block test failed");
    $finish;
  end

endmodule
